// ===== sv/sisr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package: fixed-point formats, datapath widths and rounding helper of the spin rotation pipeline
package sisr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SPIN_W = 18;
	localparam int TORQUE_W = 21;
	localparam int OUT_MAX_RAW = 131071;

	localparam int PROD_W = SPIN_W + TORQUE_W + 1;
	localparam int FSQ_W = 2 * TORQUE_W + 1;
	localparam int DOTF_W = PROD_W + TORQUE_W;
	localparam int D4_W = 2 * TORQUE_W - FRAC_BITS + 1;
	localparam int CRR_W = PROD_W - FRAC_BITS + 2;
	localparam int N4_W = SPIN_W + 2 * TORQUE_W - 2 * FRAC_BITS + 1;
	localparam int NUM_W = N4_W + FRAC_BITS;
	localparam int MQ = NUM_W - FRAC_BITS - 2;
	localparam int MDT_W = D4_W + MQ;
	localparam int M_W = MQ + 1;
	localparam int Y_W = M_W + 2;
	localparam int NSQ_W = 2 * Y_W;
	localparam int R_W = Y_W;
	localparam int ON_W = Y_W + FRAC_BITS + 1;
	localparam int OQ = FRAC_BITS + 2;
	localparam int ODT_W = R_W + OQ;
	localparam int SAT_LIM = ((1 << FRAC_BITS) > OUT_MAX_RAW) ? OUT_MAX_RAW : (1 << FRAC_BITS);

	typedef logic signed [63:0] wide_t;

	// divide by 2^s, round to nearest, ties away from zero
	function automatic wide_t rnd_shr(input wide_t v, input int s);
		logic [63:0] mag;
		logic [63:0] q;
		mag = v[63] ? 64'(-v) : 64'(v);
		q = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -wide_t'(q) : wide_t'(q);
	endfunction

endpackage
`default_nettype wire

// ===== sv/semi_implicit_spin_rotation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level: pipelined semi-implicit midpoint spin rotation with renormalization
//
// One item enters per clock unless the input side is stalled, and passes through stages s1 to s4 for the
// products and the midpoint numerator, a restoring divider with one quotient bit per stage
// (28 stages), stages s5 to s7 for Y and its squared norm, a digit-by-digit square root with one
// result bit per stage (31 stages) and a second restoring divider for the renormalization
// (19 stages), then the output register. A stall on the result side freezes every stage at once;
// the input side is stalled only while a result waits in the output register.
module semi_implicit_spin_rotation
	import sisr_pkg::*;
(
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire signed [SPIN_W-1:0] spin_x,
	input wire signed [SPIN_W-1:0] spin_y,
	input wire signed [SPIN_W-1:0] spin_z,
	input wire signed [TORQUE_W-1:0] torque_x,
	input wire signed [TORQUE_W-1:0] torque_y,
	input wire signed [TORQUE_W-1:0] torque_z,
	output logic out_valid,
	input wire out_stall,
	output logic signed [SPIN_W-1:0] new_spin_x,
	output logic signed [SPIN_W-1:0] new_spin_y,
	output logic signed [SPIN_W-1:0] new_spin_z,
	output logic degenerate
);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [SPIN_W-1:0] x_s1 [3];
	logic signed [TORQUE_W-1:0] f_s1 [3];
	logic signed [SPIN_W-1:0] x_s2 [3];
	logic signed [TORQUE_W-1:0] f_s2 [3];
	logic signed [FSQ_W-1:0] fsq_s2;
	logic signed [PROD_W-1:0] dot_s2;
	logic signed [PROD_W-1:0] cr_s2 [3];
	logic signed [SPIN_W-1:0] x_s3 [3];
	logic [D4_W-1:0] d4_s3;
	logic signed [CRR_W-1:0] crr_s3 [3];
	logic signed [DOTF_W-1:0] dotf_s3 [3];
	logic signed [SPIN_W-1:0] x_s4 [3];
	logic [D4_W-1:0] d4_s4;
	logic signed [N4_W-1:0] n4_s4 [3];

	logic md_v_sk [0:MQ];
	logic [NUM_W-1:0] md_rem_sk [0:MQ][3];
	logic md_neg_sk [0:MQ][3];
	logic [MQ-1:0] md_q_sk [0:MQ][3];
	logic [D4_W-1:0] md_d4_sk [0:MQ];
	logic signed [SPIN_W-1:0] md_x_sk [0:MQ][3];

	logic signed [Y_W-1:0] y_s5 [3];
	logic signed [Y_W-1:0] y_s6 [3];
	logic [NSQ_W-1:0] ysq_s6 [3];
	logic signed [Y_W-1:0] y_s7 [3];
	logic [NSQ_W-1:0] nsq_s7;

	logic sq_v_sk [0:R_W];
	logic [NSQ_W-1:0] sq_rem_sk [0:R_W];
	logic [NSQ_W:0] sq_res_sk [0:R_W];
	logic signed [Y_W-1:0] sq_y_sk [0:R_W][3];

	logic od_v_sk [0:OQ];
	logic [ON_W-1:0] od_rem_sk [0:OQ][3];
	logic od_neg_sk [0:OQ][3];
	logic [OQ-1:0] od_q_sk [0:OQ][3];
	logic [R_W-1:0] od_nrm_sk [0:OQ];
	logic od_degen_sk [0:OQ];

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k <= MQ; k++) md_v_sk[k] <= 1'b0;
			for (int k = 0; k <= R_W; k++) sq_v_sk[k] <= 1'b0;
			for (int k = 0; k <= OQ; k++) od_v_sk[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			md_v_sk[0] <= v_s4;
			for (int k = 1; k <= MQ; k++) md_v_sk[k] <= md_v_sk[k-1];
			v_s5 <= md_v_sk[MQ];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			sq_v_sk[0] <= v_s7;
			for (int k = 1; k <= R_W; k++) sq_v_sk[k] <= sq_v_sk[k-1];
			od_v_sk[0] <= sq_v_sk[R_W];
			for (int k = 1; k <= OQ; k++) od_v_sk[k] <= od_v_sk[k-1];
			out_valid <= od_v_sk[OQ];
		end
	end

	always_ff @(posedge clk) begin
		wide_t xe [3];
		wide_t fe [3];
		wide_t t;
		wide_t u;
		logic hit;
		logic [MDT_W-1:0] mtrial;
		logic [MDT_W-1:0] mdiff;
		logic [NSQ_W:0] sq_sum;
		logic [NSQ_W:0] sq_remx;
		logic [ODT_W-1:0] otrial;
		logic [ODT_W-1:0] odiff;
		if (adv) begin
			x_s1[0] <= spin_x;
			x_s1[1] <= spin_y;
			x_s1[2] <= spin_z;
			f_s1[0] <= torque_x;
			f_s1[1] <= torque_y;
			f_s1[2] <= torque_z;

			for (int i = 0; i < 3; i++) begin
				xe[i] = wide_t'(x_s1[i]);
				fe[i] = wide_t'(f_s1[i]);
			end
			t = fe[0] * fe[0] + fe[1] * fe[1] + fe[2] * fe[2];
			fsq_s2 <= t[FSQ_W-1:0];
			t = fe[0] * xe[0] + fe[1] * xe[1] + fe[2] * xe[2];
			dot_s2 <= t[PROD_W-1:0];
			t = xe[1] * fe[2] - xe[2] * fe[1];
			cr_s2[0] <= t[PROD_W-1:0];
			t = xe[2] * fe[0] - xe[0] * fe[2];
			cr_s2[1] <= t[PROD_W-1:0];
			t = xe[0] * fe[1] - xe[1] * fe[0];
			cr_s2[2] <= t[PROD_W-1:0];
			x_s2 <= x_s1;
			f_s2 <= f_s1;

			t = (wide_t'(4) <<< FRAC_BITS) + rnd_shr(wide_t'(fsq_s2), FRAC_BITS);
			d4_s3 <= t[D4_W-1:0];
			for (int i = 0; i < 3; i++) begin
				t = rnd_shr(wide_t'(cr_s2[i]), FRAC_BITS - 1);
				crr_s3[i] <= t[CRR_W-1:0];
				t = wide_t'(dot_s2) * wide_t'(f_s2[i]);
				dotf_s3[i] <= t[DOTF_W-1:0];
			end
			x_s3 <= x_s2;

			for (int i = 0; i < 3; i++) begin
				t = (wide_t'(x_s3[i]) <<< 2) - wide_t'(crr_s3[i])
					+ rnd_shr(wide_t'(dotf_s3[i]), 2 * FRAC_BITS);
				n4_s4[i] <= t[N4_W-1:0];
			end
			d4_s4 <= d4_s3;
			x_s4 <= x_s3;

			for (int i = 0; i < 3; i++) begin
				t = wide_t'(n4_s4[i]);
				t = (t < 0) ? -t : t;
				t = (t <<< FRAC_BITS) + wide_t'(d4_s4 >> 1);
				md_rem_sk[0][i] <= t[NUM_W-1:0];
				md_neg_sk[0][i] <= n4_s4[i][N4_W-1];
				md_q_sk[0][i] <= '0;
				md_x_sk[0][i] <= x_s4[i];
			end
			md_d4_sk[0] <= d4_s4;

			for (int k = 1; k <= MQ; k++) begin
				mtrial = MDT_W'(md_d4_sk[k-1]) << (MQ - k);
				for (int i = 0; i < 3; i++) begin
					mdiff = MDT_W'(md_rem_sk[k-1][i]) - mtrial;
					hit = MDT_W'(md_rem_sk[k-1][i]) >= mtrial;
					md_rem_sk[k][i] <= hit ? mdiff[NUM_W-1:0] : md_rem_sk[k-1][i];
					md_q_sk[k][i] <= md_q_sk[k-1][i] | (MQ'(hit) << (MQ - k));
					md_neg_sk[k][i] <= md_neg_sk[k-1][i];
					md_x_sk[k][i] <= md_x_sk[k-1][i];
				end
				md_d4_sk[k] <= md_d4_sk[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				u = wide_t'(md_q_sk[MQ][i]);
				u = md_neg_sk[MQ][i] ? -u : u;
				t = (u <<< 1) - wide_t'(md_x_sk[MQ][i]);
				y_s5[i] <= t[Y_W-1:0];
			end

			for (int i = 0; i < 3; i++) begin
				t = wide_t'(y_s5[i]) * wide_t'(y_s5[i]);
				ysq_s6[i] <= t[NSQ_W-1:0];
			end
			y_s6 <= y_s5;

			nsq_s7 <= ysq_s6[0] + ysq_s6[1] + ysq_s6[2];
			y_s7 <= y_s6;

			sq_rem_sk[0] <= nsq_s7;
			sq_res_sk[0] <= '0;
			sq_y_sk[0] <= y_s7;
			for (int k = 1; k <= R_W; k++) begin
				sq_sum = sq_res_sk[k-1] + ((NSQ_W + 1)'(1) << (2 * (R_W - k)));
				sq_remx = (NSQ_W + 1)'(sq_rem_sk[k-1]);
				if (sq_remx >= sq_sum) begin
					sq_remx = sq_remx - sq_sum;
					sq_rem_sk[k] <= sq_remx[NSQ_W-1:0];
					sq_res_sk[k] <= (sq_res_sk[k-1] >> 1)
						+ ((NSQ_W + 1)'(1) << (2 * (R_W - k)));
				end else begin
					sq_rem_sk[k] <= sq_rem_sk[k-1];
					sq_res_sk[k] <= sq_res_sk[k-1] >> 1;
				end
				sq_y_sk[k] <= sq_y_sk[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				t = wide_t'(sq_y_sk[R_W][i]);
				t = (t < 0) ? -t : t;
				t = (t <<< FRAC_BITS) + wide_t'(sq_res_sk[R_W][R_W-1:0] >> 1);
				od_rem_sk[0][i] <= t[ON_W-1:0];
				od_neg_sk[0][i] <= sq_y_sk[R_W][i][Y_W-1];
				od_q_sk[0][i] <= '0;
			end
			od_nrm_sk[0] <= sq_res_sk[R_W][R_W-1:0];
			od_degen_sk[0] <= sq_res_sk[R_W][R_W-1:0] == '0;

			for (int k = 1; k <= OQ; k++) begin
				otrial = ODT_W'(od_nrm_sk[k-1]) << (OQ - k);
				for (int i = 0; i < 3; i++) begin
					odiff = ODT_W'(od_rem_sk[k-1][i]) - otrial;
					hit = ODT_W'(od_rem_sk[k-1][i]) >= otrial;
					od_rem_sk[k][i] <= hit ? odiff[ON_W-1:0] : od_rem_sk[k-1][i];
					od_q_sk[k][i] <= od_q_sk[k-1][i] | (OQ'(hit) << (OQ - k));
					od_neg_sk[k][i] <= od_neg_sk[k-1][i];
				end
				od_nrm_sk[k] <= od_nrm_sk[k-1];
				od_degen_sk[k] <= od_degen_sk[k-1];
			end

			// clamp and drop the quotient when the norm is zero
			for (int i = 0; i < 3; i++) begin
				u = wide_t'(od_q_sk[OQ][i]);
				u = od_neg_sk[OQ][i] ? -u : u;
				if (u > wide_t'(SAT_LIM)) u = wide_t'(SAT_LIM);
				if (u < -wide_t'(SAT_LIM)) u = -wide_t'(SAT_LIM);
				if (od_degen_sk[OQ]) u = '0;
				xe[i] = u;
			end
			new_spin_x <= xe[0][SPIN_W-1:0];
			new_spin_y <= xe[1][SPIN_W-1:0];
			new_spin_z <= xe[2][SPIN_W-1:0];
			degenerate <= od_degen_sk[OQ];
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> new_spin_x == '0 && new_spin_y == '0 && new_spin_z == '0)
		else $error("degenerate item with nonzero spin");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> new_spin_x != '0 || new_spin_y != '0 || new_spin_z != '0)
		else $error("normalized item is all zero");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_spin_x <= SAT_LIM && new_spin_x >= -SAT_LIM
			&& new_spin_y <= SAT_LIM && new_spin_y >= -SAT_LIM
			&& new_spin_z <= SAT_LIM && new_spin_z >= -SAT_LIM)
		else $error("spin component beyond saturation limit");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s4) && $stable(sq_v_sk[R_W]) && $stable(out_valid))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
